/* hw/rtl/rhc_pkg.sv */
// Package: widths and shared types for the RGB to HSV converter.
package rhc_pkg;
    localparam int CHANNEL_BITS  = 8;
    localparam int HUE_FRAC_BITS = 6;
    localparam int HUE_BITS      = 15;
    localparam int SAT_BITS      = 8;
    localparam int QUO_BITS      = 12;
    localparam int DEN_BITS      = 8;
    localparam int NUM_BITS      = 16;

    localparam logic [1:0] SEL_RED   = 2'd1;
    localparam logic [1:0] SEL_GREEN = 2'd2;
    localparam logic [1:0] SEL_BLUE  = 2'd3;

    // Data handed from one divider cell to the next.
    typedef struct packed {
        logic                  valid;
        logic [DEN_BITS-1:0]   hue_rem;
        logic [DEN_BITS-1:0]   hue_den;
        logic [NUM_BITS-1:0]   hue_num;
        logic [QUO_BITS-1:0]   hue_quo;
        logic [NUM_BITS-1:0]   sat_num;
        logic [DEN_BITS-1:0]   sat_rem;
        logic [DEN_BITS-1:0]   sat_den;
        logic [SAT_BITS-1:0]   sat_quo;
        logic [1:0]            sel;
        logic                  neg;
        logic                  grey;
        logic [CHANNEL_BITS-1:0] bright;
    } cell_word_t;
endpackage

/* hw/rtl/rhc_stream_if.sv */
// Interface: valid/ready channel carrying a payload word.
interface rhc_stream_if #(parameter int W = 24);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rhc_div_cell.sv */
// Divider cell: one restoring step for the hue and saturation quotients.
module rhc_div_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  rhc_pkg::cell_word_t in_word,
    output rhc_pkg::cell_word_t out_word_reg
);
    localparam int PAY_BITS = $bits(rhc_pkg::cell_word_t) - 1;

    rhc_pkg::cell_word_t w_next;
    logic                valid_reg;
    logic [PAY_BITS-1:0] payload_reg;
    logic [rhc_pkg::DEN_BITS:0] htry;
    logic [rhc_pkg::DEN_BITS:0] stry;
    logic [rhc_pkg::DEN_BITS:0] hsub;
    logic [rhc_pkg::DEN_BITS:0] ssub;

    // Shift in one numerator bit and try subtracting the divisor.
    always_comb
    begin
        w_next = in_word;
        htry = {in_word.hue_rem, in_word.hue_num[rhc_pkg::NUM_BITS-1]};
        hsub = htry - {1'b0, in_word.hue_den};
        w_next.hue_num = {in_word.hue_num[rhc_pkg::NUM_BITS-2:0], 1'b0};
        if (!hsub[rhc_pkg::DEN_BITS])
        begin
            w_next.hue_rem = hsub[rhc_pkg::DEN_BITS-1:0];
            w_next.hue_quo = {in_word.hue_quo[rhc_pkg::QUO_BITS-2:0], 1'b1};
        end
        else
        begin
            w_next.hue_rem = htry[rhc_pkg::DEN_BITS-1:0];
            w_next.hue_quo = {in_word.hue_quo[rhc_pkg::QUO_BITS-2:0], 1'b0};
        end
        stry = {in_word.sat_rem, in_word.sat_num[rhc_pkg::NUM_BITS-1]};
        ssub = stry - {1'b0, in_word.sat_den};
        w_next.sat_num = {in_word.sat_num[rhc_pkg::NUM_BITS-2:0], 1'b0};
        if (!ssub[rhc_pkg::DEN_BITS])
        begin
            w_next.sat_rem = ssub[rhc_pkg::DEN_BITS-1:0];
            w_next.sat_quo = {in_word.sat_quo[rhc_pkg::SAT_BITS-2:0], 1'b1};
        end
        else
        begin
            w_next.sat_rem = stry[rhc_pkg::DEN_BITS-1:0];
            w_next.sat_quo = {in_word.sat_quo[rhc_pkg::SAT_BITS-2:0], 1'b0};
        end
    end

    // Advance when the chain moves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_word.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            payload_reg <= w_next[PAY_BITS-1:0];
    end

    assign out_word_reg = {valid_reg, payload_reg};
endmodule

/* hw/rtl/rgb_to_hsv_convert.sv */
// RGB to HSV converter: combinational front, chain of 16 divider cells, output stage.
// Pipeline: 17 register stages (16 cells and the output register); the input word
// passes through them in order and leaves the output register as the result word.
// Throughput: one pixel per cycle; the divider cell chain advances every cycle
// unless the output register is full and not taken.
// Reset clears the valid bits of every stage; payload is not reset.
module rgb_to_hsv_convert
(
    input  logic clk,
    input  logic rst_n,
    rhc_stream_if.sink   pix_in,
    rhc_stream_if.source hsv_out
);
    localparam int NCELL = rhc_pkg::NUM_BITS;
    rhc_pkg::cell_word_t chain [NCELL+1];
    logic en;
    logic out_valid_reg;
    logic [rhc_pkg::HUE_BITS-1:0] hue_reg;
    logic [7:0] sat_reg;
    logic [7:0] bright_reg;
    logic [7:0] r, g, b, mx, mn, rng, d;
    logic [11:0] hue_mul;
    logic [1:0] sel;
    logic neg;
    rhc_pkg::cell_word_t front;
    rhc_pkg::cell_word_t last;
    logic [rhc_pkg::QUO_BITS-1:0] q;
    logic [rhc_pkg::HUE_BITS:0] h;

    assign en = !out_valid_reg || hsv_out.ready;
    assign pix_in.ready = en;
    assign r = pix_in.data[23:16];
    assign g = pix_in.data[15:8];
    assign b = pix_in.data[7:0];

    // Pick largest channel, range and signed hue difference.
    always_comb
    begin
        if (r > g)
        begin
            if (b > r) begin mx = b; sel = rhc_pkg::SEL_BLUE; end
            else begin mx = r; sel = rhc_pkg::SEL_RED; end
        end
        else
        begin
            if (b > g) begin mx = b; sel = rhc_pkg::SEL_BLUE; end
            else begin mx = g; sel = rhc_pkg::SEL_GREEN; end
        end
        mn = (r < g) ? r : g;
        if (b < mn) mn = b;
        rng = mx - mn;
        unique case (sel)
            rhc_pkg::SEL_RED:   begin neg = g < b; d = neg ? b - g : g - b; end
            rhc_pkg::SEL_GREEN: begin neg = b < r; d = neg ? r - b : b - r; end
            default:            begin neg = r < g; d = neg ? g - r : r - g; end
        endcase
        // 60*64 = 15*256, so q = floor((15*d << 8) / rng). Seed the remainder
        // with the top bits of 15*d, which stay below rng, and shift the rest in.
        hue_mul = {d, 4'b0} - {4'b0, d};
        front = '0;
        front.valid   = pix_in.valid;
        front.hue_den = rng;
        front.hue_rem = {4'b0, hue_mul[11:8]};
        front.hue_num = {hue_mul[7:0], 8'd0};
        front.sat_num = {8'd0, rng} * 16'd255;
        front.sat_den = mx;
        front.sel     = sel;
        front.neg     = neg;
        front.grey    = (rng == 8'd0);
        front.bright  = mx;
    end

    assign chain[0] = front;

    genvar i;
    generate
        for (i = 0; i < NCELL; i++)
        begin : g_cell
            rhc_div_cell u_cell
            (
                .clk          (clk),
                .rst_n        (rst_n),
                .en           (en),
                .in_word      (chain[i]),
                .out_word_reg (chain[i+1])
            );
        end
    endgenerate

    assign last = chain[NCELL];

    // Form final hue with sector offset and wrap.
    always_comb
    begin
        q = last.hue_quo;
        unique case (last.sel)
            rhc_pkg::SEL_RED:
                h = last.neg ? 16'd23040 - {4'b0, q} : {4'b0, q};
            rhc_pkg::SEL_GREEN:
                h = last.neg ? 16'd7680 - {4'b0, q} : 16'd7680 + {4'b0, q};
            default:
                h = last.neg ? 16'd15360 - {4'b0, q} : 16'd15360 + {4'b0, q};
        endcase
        if (h >= 16'd23040) h = h - 16'd23040;
    end

    // Hold result until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg    <= last.grey ? '0 : h[rhc_pkg::HUE_BITS-1:0];
            sat_reg    <= last.grey ? 8'd0 : last.sat_quo;
            bright_reg <= last.bright;
        end
    end

    assign hsv_out.valid = out_valid_reg;
    assign hsv_out.data  = {hue_reg, sat_reg, bright_reg};
endmodule
